// ===== hw/rtl/cdte_pkg.sv =====
// Package: widths, constants, stage payload types and the month table for the converter.
`timescale 1ns / 1ps

package cdte_pkg;

    // Field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned EPOCH_W = 32;

    // Internal widths
    localparam int unsigned YP_W   = 15;  // year shifted up by one era
    localparam int unsigned ERA_W  = 6;   // era count, also shifted up by one
    localparam int unsigned YOE_W  = 9;   // year of era, 0..399
    localparam int unsigned DOY_W  = 9;   // day of year plus one, 0..398
    localparam int unsigned DOE_W  = 18;  // day of era plus one
    localparam int unsigned EDAY_W = 23;  // era count times days per era
    localparam int unsigned TOD_W  = 17;  // seconds into the day

    localparam logic [YEAR_W-1:0]  MIN_YEAR_RST = 14'd2024;
    localparam logic [YP_W-1:0]    ERA_YEARS    = 15'd400;
    localparam logic [MONTH_W-1:0] FEB          = 4'd2;

    // floor(x / 25) for x < 1100 as (x * 1311) >> 15
    localparam logic [10:0] RECIP_25_HI = 11'd1311;
    // floor(x / 25) for x < 100 as (x * 41) >> 10
    localparam logic [5:0]  RECIP_25_LO = 6'd41;

    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [17:0]        DAYS_PER_ERA  = 18'd146097;
    // days to the epoch plus one era (era bias) plus one (day-of-year bias)
    localparam logic [EPOCH_W-1:0] DAYS_BIAS     = 32'd865566;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]         SECS_PER_MIN  = 6'd60;

    // Stage 1: decoded fields
    typedef struct packed {
        logic              ok;
        logic [YP_W-1:0]   yp;
        logic [DOY_W-1:0]  doy;
        logic [TOD_W-1:0]  tod;
    } front_t;

    // Stage 2: era found
    typedef struct packed {
        logic              ok;
        logic [ERA_W-1:0]  era;
        logic [YP_W-1:0]   yp;
        logic [DOY_W-1:0]  doy;
        logic [TOD_W-1:0]  tod;
    } era_t;

    // Stage 3: year of era found
    typedef struct packed {
        logic              ok;
        logic [ERA_W-1:0]  era;
        logic [YOE_W-1:0]  yoe;
        logic [DOY_W-1:0]  doy;
        logic [TOD_W-1:0]  tod;
    } yoe_t;

    // Stage 4: day of era and era days
    typedef struct packed {
        logic              ok;
        logic [EDAY_W-1:0] era_days;
        logic [DOE_W-1:0]  doe;
        logic [TOD_W-1:0]  tod;
    } doe_t;

    // Stage 5: days since the epoch, modulo 2^32
    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] days;
        logic [TOD_W-1:0]   tod;
    } days_t;

    // Days from 1 March to the first of the month, (153 * mp + 2) / 5
    function automatic logic [DOY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] d;
        begin
            case (month)
                4'd0:    d = 9'd275;
                4'd1:    d = 9'd306;
                4'd2:    d = 9'd337;
                4'd3:    d = 9'd0;
                4'd4:    d = 9'd31;
                4'd5:    d = 9'd61;
                4'd6:    d = 9'd92;
                4'd7:    d = 9'd122;
                4'd8:    d = 9'd153;
                4'd9:    d = 9'd184;
                4'd10:   d = 9'd214;
                4'd11:   d = 9'd245;
                4'd12:   d = 9'd275;
                4'd13:   d = 9'd306;
                4'd14:   d = 9'd337;
                default: d = 9'd367;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== hw/rtl/cdte_req_if.sv =====
// Interface: date and time beat into the converter.
`timescale 1ns / 1ps

interface cdte_req_if;
    logic                          valid;
    logic                          ready;
    logic [cdte_pkg::YEAR_W-1:0]   year;
    logic [cdte_pkg::MONTH_W-1:0]  month;
    logic [cdte_pkg::DAY_W-1:0]    day;
    logic [cdte_pkg::HOUR_W-1:0]   hour;
    logic [cdte_pkg::MIN_W-1:0]    minute;
    logic [cdte_pkg::SEC_W-1:0]    second;
    logic                          date_valid;
    logic                          time_valid;

    modport source (
        output valid, year, month, day, hour, minute, second, date_valid, time_valid,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, second, date_valid, time_valid,
        output ready
    );
endinterface

// ===== hw/rtl/cdte_rsp_if.sv =====
// Interface: epoch seconds beat out of the converter.
`timescale 1ns / 1ps

interface cdte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cdte_pkg::EPOCH_W-1:0]  epoch_seconds;

    modport source (
        output valid, epoch_seconds,
        input  ready
    );
    modport sink (
        input  valid, epoch_seconds,
        output ready
    );
endinterface

// ===== hw/rtl/cdte_front.sv =====
// Stage 1: checks flags and year, shifts the year, looks up the month, sums time of day.
`timescale 1ns / 1ps

module cdte_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [cdte_pkg::YEAR_W-1:0]  min_year,
    cdte_req_if.sink                     req,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cdte_pkg::front_t             out_data
);

    logic               valid_reg;
    cdte_pkg::front_t   data_reg;
    cdte_pkg::front_t   data_next;
    logic               stage_ready;
    logic [16:0]        hour_secs;
    logic [11:0]        min_secs;

    // January and February belong to the previous March-based year
    always_comb
    begin
        hour_secs          = 17'(req.hour * cdte_pkg::SECS_PER_HOUR);
        min_secs           = 12'(req.minute * cdte_pkg::SECS_PER_MIN);
        data_next.ok       = req.date_valid & req.time_valid & (req.year >= min_year);
        data_next.yp       = {1'b0, req.year} + cdte_pkg::ERA_YEARS
                             - {14'd0, (req.month <= cdte_pkg::FEB)};
        data_next.doy      = cdte_pkg::month_days(req.month) + {4'd0, req.day};
        data_next.tod      = hour_secs + {5'd0, min_secs} + {11'd0, req.second};
    end

    assign stage_ready = !valid_reg || out_ready;
    assign req.ready   = stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && req.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/cdte_era.sv =====
// Stages 2 and 3: splits the shifted year into era and year of era.
`timescale 1ns / 1ps

module cdte_era (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cdte_pkg::front_t      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cdte_pkg::yoe_t        out_data
);

    logic              v2_reg;
    logic              v3_reg;
    cdte_pkg::era_t    d2_reg;
    cdte_pkg::era_t    d2_next;
    cdte_pkg::yoe_t    d3_reg;
    cdte_pkg::yoe_t    d3_next;
    logic              rdy2;
    logic              rdy3;
    logic [21:0]       quot_prod;
    logic [14:0]       era_years;

    // Era: floor(yp / 400) = floor((yp >> 4) / 25) by reciprocal multiply
    always_comb
    begin
        quot_prod   = 22'(in_data.yp[14:4] * cdte_pkg::RECIP_25_HI);
        d2_next.ok  = in_data.ok;
        d2_next.era = quot_prod[20:15];
        d2_next.yp  = in_data.yp;
        d2_next.doy = in_data.doy;
        d2_next.tod = in_data.tod;
    end

    // Year of era is what the era leaves over
    always_comb
    begin
        era_years   = 15'(d2_reg.era * cdte_pkg::ERA_YEARS);
        d3_next.ok  = d2_reg.ok;
        d3_next.era = d2_reg.era;
        d3_next.yoe = 9'(d2_reg.yp - era_years);
        d3_next.doy = d2_reg.doy;
        d3_next.tod = d2_reg.tod;
    end

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && in_valid)
        begin
            d2_reg <= d2_next;
        end
        if (rdy3 && v2_reg)
        begin
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// ===== hw/rtl/cdte_days.sv =====
// Stages 4 and 5: day of era, era days and the day count since the epoch.
`timescale 1ns / 1ps

module cdte_days (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cdte_pkg::yoe_t        in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cdte_pkg::days_t       out_data
);

    logic              v4_reg;
    logic              v5_reg;
    cdte_pkg::doe_t    d4_reg;
    cdte_pkg::doe_t    d4_next;
    cdte_pkg::days_t   d5_reg;
    cdte_pkg::days_t   d5_next;
    logic              rdy4;
    logic              rdy5;
    logic [17:0]       yoe_days;
    logic [12:0]       cent_prod;
    logic [1:0]        cents;

    // Day of era: yoe*365 + yoe/4 - yoe/100 + day of year (plus one)
    always_comb
    begin
        yoe_days         = 18'(in_data.yoe * cdte_pkg::DAYS_PER_YEAR);
        cent_prod        = 13'(in_data.yoe[8:2] * cdte_pkg::RECIP_25_LO);
        cents            = cent_prod[11:10];
        d4_next.ok       = in_data.ok;
        d4_next.era_days = 23'(in_data.era * cdte_pkg::DAYS_PER_ERA);
        d4_next.doe      = yoe_days + {11'd0, in_data.yoe[8:2]} - {16'd0, cents}
                           + {9'd0, in_data.doy};
        d4_next.tod      = in_data.tod;
    end

    // Remove the era shift, the day bias and the days before 1970; wraps mod 2^32
    always_comb
    begin
        d5_next.ok   = d4_reg.ok;
        d5_next.days = {9'd0, d4_reg.era_days} + {14'd0, d4_reg.doe} - cdte_pkg::DAYS_BIAS;
        d5_next.tod  = d4_reg.tod;
    end

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            d4_reg <= d4_next;
        end
        if (rdy5 && v4_reg)
        begin
            d5_reg <= d5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = d5_reg;

endmodule

// ===== hw/rtl/civil_date_to_epoch_seconds.sv =====
// Top level: civil date and time of day to 32-bit seconds since 1970.
`timescale 1ns / 1ps

// Converts a Gregorian date and time of day to seconds since 1970-01-01 00:00:00,
// modulo 2^32, by the days-from-civil method (March-based years, 400-year eras).
// The result is 0 when either validity flag is low or the year is below min_year
// (reset value 2024). A six-stage pipeline takes one beat per cycle while req.ready is
// high. The slowest stage is the final 32-bit multiply by 86400. Back-pressure on
// rsp holds each full stage while empty stages still fill, and req.ready falls only
// once all stages are full. Write min_year only while idle.
module civil_date_to_epoch_seconds (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cdte_pkg::YEAR_W-1:0]  cfg_wdata,
    cdte_req_if.sink                     req,
    cdte_rsp_if.source                   rsp
);

    logic [cdte_pkg::YEAR_W-1:0]   min_year_reg;
    logic                          s1_valid;
    logic                          s1_ready;
    cdte_pkg::front_t              s1_data;
    logic                          s3_valid;
    logic                          s3_ready;
    cdte_pkg::yoe_t                s3_data;
    logic                          s5_valid;
    logic                          s5_ready;
    cdte_pkg::days_t               s5_data;
    logic                          out_valid_reg;
    logic [cdte_pkg::EPOCH_W-1:0]  secs_reg;
    logic [cdte_pkg::EPOCH_W-1:0]  secs_next;
    logic [cdte_pkg::EPOCH_W-1:0]  day_secs;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= cdte_pkg::MIN_YEAR_RST;
        end
        else if (cfg_we)
        begin
            min_year_reg <= cfg_wdata;
        end
    end

    cdte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_year  (min_year_reg),
        .req       (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    cdte_era u_era (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    cdte_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (s5_valid),
        .out_ready (s5_ready),
        .out_data  (s5_data)
    );

    // Stage 6: days to seconds, add time of day, zero on a rejected beat
    always_comb
    begin
        day_secs  = s5_data.days * cdte_pkg::SECS_PER_DAY;
        secs_next = s5_data.ok ? (day_secs + {15'd0, s5_data.tod}) : '0;
    end

    assign s5_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            out_valid_reg <= s5_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s5_valid)
        begin
            secs_reg <= secs_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.epoch_seconds = secs_reg;

endmodule
